// ===== rtl/ray_reflect_refract_top_defines.svh =====
// Assertion macros for the ray reflect/refract block.
// Used by ray_reflect_refract_top; expects signals named clock and reset in scope.
`ifndef RAY_REFLECT_REFRACT_TOP_DEFINES_SVH
`define RAY_REFLECT_REFRACT_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define RRR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define RRR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rrr_pkg.sv =====
// Shared types and constants for the ray reflect/refract block.
// No dependencies; imported by every rrr_ module and the top level.
package rrr_pkg;

   localparam int ETA_W        = 25;
   localparam int DOT_W        = 33;
   localparam int QDEPTH       = 4;
   localparam int QPTR_W       = $clog2(QDEPTH);
   localparam int RECIP_STEPS  = 25;
   localparam int RECIP_CNT_W  = $clog2(RECIP_STEPS + 1);

   localparam logic [15:0]      INDEX_RESET  = 16'd4096;
   localparam logic [47:0]      COLOUR_RESET = 48'd0;
   localparam logic [ETA_W-1:0] RECIP_RESET  = 25'd4096;

   typedef enum logic [0:0] {
      CSR_REFRACTIVE_INDEX = 1'b0,
      CSR_OBJECT_COLOUR    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [59:0]        hit_point;
      logic [47:0]        ray_colour;
      logic [7:0]         ray_level;
   } rrr_req_type;

   typedef struct packed {
      logic [59:0]        new_origin;
      logic signed [15:0] new_dir_x;
      logic signed [15:0] new_dir_y;
      logic signed [15:0] new_dir_z;
      logic [47:0]        new_colour;
      logic [7:0]         new_level;
      logic               total_reflection;
   } rrr_rsp_type;

   // Classified request handed from front to back.
   typedef struct packed {
      rrr_req_type              req;
      logic signed [DOT_W-1:0]  dot;
      logic [ETA_W-1:0]         eta;
   } rrr_mid_type;

endpackage

// ===== rtl/ray_reflect_refract_top.sv =====
// Channel | ports                                      | moves on
// req     | req_push, req_full, req_data               | push && !full
// rsp     | rsp_pop, rsp_empty, rsp_data               | pop && !empty
// csr     | csr_valid, csr_ready, csr_index, csr_data  | valid && ready
//
// One request per cycle sustained while req_full is low; a result reaches rsp_data after
// its request passes the input register, the queue and the 40-stage back pipeline with
// a 32-step root.
// Reset is synchronous and needs no clearing pass; index starts at 1.0.
// Writing the refractive index starts the reciprocal divide; req_full stays high while it runs.
// A result not popped stalls the back pipeline; the queue then fills and raises req_full.
// Depends on rrr_pkg, rrr_recip, rrr_front, rrr_queue, rrr_back and the defines header.
`include "ray_reflect_refract_top_defines.svh"

module ray_reflect_refract_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  rrr_pkg::rrr_req_type  req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rrr_pkg::rrr_rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rrr_pkg::csr_index_type csr_index,
   input  logic [47:0]           csr_data
);
   import rrr_pkg::*;

   logic [15:0]      index_ff, index_in;
   logic [47:0]      colour_ff, colour_in;
   logic             csr_write;
   logic             recip_start;
   logic             recip_busy;
   logic [ETA_W-1:0] recip;
   logic             q_ready, q_push, q_valid, q_pop;
   rrr_mid_type      q_wdata, q_rdata;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign recip_start = csr_write && (csr_index == CSR_REFRACTIVE_INDEX);

   always_comb begin
      index_in  = index_ff;
      colour_in = colour_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_REFRACTIVE_INDEX: index_in  = csr_data[15:0];
            CSR_OBJECT_COLOUR:    colour_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= INDEX_RESET;
         colour_ff <= COLOUR_RESET;
      end else begin
         index_ff  <= index_in;
         colour_ff <= colour_in;
      end
   end

   rrr_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start),
      .divisor (csr_data[15:0]),
      .busy    (recip_busy),
      .quot    (recip)
   );

   rrr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .recip_busy       (recip_busy),
      .refractive_index (index_ff),
      .recip            (recip),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_data           (q_wdata)
   );

   rrr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .ready    (q_ready),
      .valid    (q_valid),
      .data_out (q_rdata),
      .pop      (q_pop)
   );

   rrr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_rdata),
      .q_pop         (q_pop),
      .object_colour (colour_ff),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data)
   );

   `RRR_ASSERT_NOW(a_busy_blocks_req, recip_busy, req_full, "request taken during reciprocal update")
   `RRR_ASSERT_NEXT(a_index_write_stalls, recip_start, req_full && recip_busy, "index write did not stall requests")
   `RRR_ASSERT_NOW(a_level_nonzero, !rsp_empty, rsp_data.new_level != 8'd0, "result level is zero")

endmodule

// ===== rtl/rrr_recip.sv =====
// Iterative reciprocal of the refractive index, round(2^24 / index), one bit a cycle.
// Depends on rrr_pkg.
module rrr_recip (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [15:0]               divisor,
   output logic                      busy,
   output logic [rrr_pkg::ETA_W-1:0] quot
);
   import rrr_pkg::*;

   logic [RECIP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]            dv_ff, dv_in;
   logic [ETA_W-1:0]       num_ff, num_in;
   logic [15:0]            rem_ff, rem_in;
   logic [ETA_W-1:0]       q_ff, q_in;
   logic [ETA_W-1:0]       quot_ff, quot_in;
   logic [16:0]            rem_sh;
   logic                   ge;
   logic [15:0]            dv_start;

   always_comb begin
      dv_start = (divisor == 16'd0) ? 16'd1 : divisor;
      rem_sh   = {rem_ff, num_ff[ETA_W-1]};
      ge       = rem_sh >= {1'b0, dv_ff};
      cnt_in   = cnt_ff;
      dv_in    = dv_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      quot_in  = quot_ff;
      if (start) begin
         cnt_in = RECIP_CNT_W'(RECIP_STEPS);
         dv_in  = dv_start;
         num_in = (ETA_W'(1) << 24) + ETA_W'(dv_start >> 1);
         rem_in = 16'd0;
      end else if (busy) begin
         cnt_in = cnt_ff - RECIP_CNT_W'(1);
         num_in = {num_ff[ETA_W-2:0], 1'b0};
         rem_in = ge ? 16'(rem_sh - {1'b0, dv_ff}) : rem_sh[15:0];
         q_in   = {q_ff[ETA_W-2:0], ge};
         if (cnt_ff == RECIP_CNT_W'(1)) begin
            quot_in = {q_ff[ETA_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         quot_ff <= RECIP_RESET;
      end else begin
         cnt_ff  <= cnt_in;
         quot_ff <= quot_in;
      end
      dv_ff  <= dv_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign busy = cnt_ff != '0;
   assign quot = quot_ff;

endmodule

// ===== rtl/rrr_front.sv =====
// Front end: takes requests, forms the dot product and selects eta.
// Depends on rrr_pkg; feeds rrr_queue.
module rrr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  rrr_pkg::rrr_req_type      req_data,
   input  logic                      recip_busy,
   input  logic [15:0]               refractive_index,
   input  logic [rrr_pkg::ETA_W-1:0] recip,
   input  logic                      q_ready,
   output logic                      q_push,
   output rrr_pkg::rrr_mid_type      q_data
);
   import rrr_pkg::*;

   logic        f_valid_ff, f_valid_in;
   rrr_req_type f_req_ff;
   logic        accept;
   logic signed [DOT_W-1:0] dot;

   assign req_full   = recip_busy || (f_valid_ff && !q_ready);
   assign accept     = req_push && !req_full;
   assign f_valid_in = accept || (f_valid_ff && !q_ready);
   assign q_push     = f_valid_ff && q_ready;

   always_comb begin
      dot = DOT_W'(f_req_ff.dir_x) * DOT_W'(f_req_ff.norm_x)
          + DOT_W'(f_req_ff.dir_y) * DOT_W'(f_req_ff.norm_y)
          + DOT_W'(f_req_ff.dir_z) * DOT_W'(f_req_ff.norm_z);
      q_data.req = f_req_ff;
      q_data.dot = dot;
      // leaving the dense side uses the index itself, entering uses its reciprocal
      q_data.eta = (dot > 0) ? ETA_W'(refractive_index) : recip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      if (accept) begin
         f_req_ff <= req_data;
      end
   end

endmodule

// ===== rtl/rrr_queue.sv =====
// Short queue of classified requests between front and back.
// Depends on rrr_pkg.
module rrr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rrr_pkg::rrr_mid_type data_in,
   output logic                 ready,
   output logic                 valid,
   output rrr_pkg::rrr_mid_type data_out,
   input  logic                 pop
);
   import rrr_pkg::*;

   rrr_mid_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign ready    = count_ff != (QPTR_W+1)'(QDEPTH);
   assign valid    = count_ff != '0;
   assign data_out = mem_ff[rd_ptr_ff];
   assign do_push  = push && ready;
   assign do_pop   = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ===== rtl/rrr_back.sv =====
// Back end: stalling pipeline for reflection, refraction, square root and colour.
// Depends on rrr_pkg; pulls from rrr_queue and holds the result register.
module rrr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  rrr_pkg::rrr_mid_type q_data,
   output logic                 q_pop,
   input  logic [47:0]          object_colour,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rrr_pkg::rrr_rsp_type rsp_data
);
   import rrr_pkg::*;

   localparam int SQ_STEPS = 32;
   localparam int NSTAGE   = 4 + (SQ_STEPS + 1) + 3;
   localparam logic [66:0] PROD_LIMIT = 67'd1 << 62;
   localparam logic [62:0] ONE_Q32    = 63'd1 << 32;

   typedef struct packed {
      rrr_req_type        req;
      logic [ETA_W-1:0]   eta;
      logic [47:0]        new_colour;
      logic [7:0]         new_level;
      logic signed [15:0] refl_x;
      logic signed [15:0] refl_y;
      logic signed [15:0] refl_z;
      logic [33:0]        eb;
      logic               tir;
   } ctx_type;

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] dir_of(input rrr_req_type r, input logic [1:0] i);
      case (i)
         2'd0:    return r.dir_x;
         2'd1:    return r.dir_y;
         default: return r.dir_z;
      endcase
   endfunction

   function automatic logic signed [15:0] norm_of(input rrr_req_type r, input logic [1:0] i);
      case (i)
         2'd0:    return r.norm_x;
         2'd1:    return r.norm_y;
         default: return r.norm_z;
      endcase
   endfunction

   logic              en;
   logic [NSTAGE-1:0] vld_ff;

   // stage 1
   ctx_type            ctx1_ff, ctx1_in;
   logic [20:0]        b16_ff, b16_in;
   logic signed [48:0] pr_ff [3];
   logic signed [48:0] pr_in [3];
   logic [49:0]        etasq_ff, etasq_in;
   logic [31:0]        colp_ff [3];
   logic [31:0]        colp_in [3];
   logic [32:0]        abs_dot;
   // stage 2
   ctx_type            ctx2_ff, ctx2_in;
   logic [24:0]        b2_ff, b2_in;
   logic [41:0]        eta2_ff, eta2_in;
   logic [45:0]        ebp_ff, ebp_in;
   logic [41:0]        b16sq;
   logic signed [51:0] rv [3];
   logic signed [15:0] refl [3];
   logic [31:0]        col_r [3];
   // stage 3
   ctx_type            ctx3_ff, ctx3_in;
   logic               msign3_ff, msign3_in;
   logic [45:0]        pplo_ff, pplo_in, pphi_ff, pphi_in;
   logic [24:0]        absm;
   // stage 4
   ctx_type            ctx4_ff, ctx4_in;
   logic               msign4_ff;
   logic [62:0]        pm_ff, pm_in;
   logic [66:0]        pmf;
   // stage 5 and square root steps
   ctx_type            sq_ctx_ff  [SQ_STEPS+1];
   logic [63:0]        sq_rem_ff  [SQ_STEPS+1];
   logic [31:0]        sq_root_ff [SQ_STEPS+1];
   ctx_type            ctx5_in;
   logic [62:0]        k_in;
   logic               kneg;
   // tail stages
   ctx_type            ct1_ff, ct2_ff;
   logic signed [34:0] t_ff, t_in;
   logic signed [41:0] ed1_ff [3];
   logic signed [41:0] ed1_in [3];
   logic signed [41:0] ed2_ff [3];
   logic signed [50:0] tn_ff [3];
   logic signed [50:0] tn_in [3];
   logic signed [52:0] fv [3];
   logic signed [15:0] frac [3];
   logic signed [15:0] fdir [3];
   rrr_rsp_type        rsp_ff, rsp_in;
   logic               use_refr;

   assign en        = !vld_ff[NSTAGE-1] || rsp_pop;
   assign q_pop     = en && q_valid;
   assign rsp_empty = !vld_ff[NSTAGE-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], q_valid};
      end
   end

   // stage 1: |dot|, reflection products, eta squared, colour products, next level
   always_comb begin
      ctx1_in            = '0;
      ctx1_in.req        = q_data.req;
      ctx1_in.eta        = q_data.eta;
      ctx1_in.new_level  = (q_data.req.ray_level == 8'hFF) ? 8'hFF
                                                           : q_data.req.ray_level + 8'd1;
      abs_dot  = q_data.dot[DOT_W-1] ? 33'(-q_data.dot) : 33'(q_data.dot);
      b16_in   = 21'((34'(abs_dot) + 34'd2048) >> 12);
      etasq_in = 50'(q_data.eta) * 50'(q_data.eta);
      for (int i = 0; i < 3; i++) begin
         pr_in[i]   = 49'(q_data.dot) * 49'(norm_of(q_data.req, 2'(i)));
         colp_in[i] = 32'(q_data.req.ray_colour[16*i +: 16]) * 32'(object_colour[16*i +: 16]);
      end
   end

   // stage 2: B squared, eta2, eta*B, finished reflection and colour
   always_comb begin
      ctx2_in  = ctx1_ff;
      b16sq    = 42'(b16_ff) * 42'(b16_ff);
      b2_in    = 25'((b16sq + 42'd32768) >> 16);
      eta2_in  = 42'((etasq_ff + 50'd128) >> 8);
      ebp_in   = 46'(ctx1_ff.eta) * 46'(b16_ff);
      for (int i = 0; i < 3; i++) begin
         rv[i]    = (52'(dir_of(ctx1_ff.req, 2'(i))) <<< 28) - (52'(pr_ff[i]) <<< 1)
                  + 52'sd134217728;
         refl[i]  = sat16(64'(rv[i] >>> 28));
         col_r[i] = (colp_ff[i] + 32'd32768) >> 16;
      end
      ctx2_in.refl_x     = refl[0];
      ctx2_in.refl_y     = refl[1];
      ctx2_in.refl_z     = refl[2];
      ctx2_in.new_colour = {col_r[2][15:0], col_r[1][15:0], col_r[0][15:0]};
   end

   // stage 3: |B^2 - 1| and the split product with eta2
   always_comb begin
      ctx3_in    = ctx2_ff;
      ctx3_in.eb = 34'((ebp_ff + 46'd2048) >> 12);
      msign3_in  = b2_ff < 25'd65536;
      absm       = msign3_in ? 25'(25'd65536 - b2_ff) : 25'(b2_ff - 25'd65536);
      pplo_in    = 46'(eta2_ff[20:0]) * 46'(absm);
      pphi_in    = 46'(eta2_ff[41:21]) * 46'(absm);
   end

   // stage 4: join partial products, clamp magnitude
   always_comb begin
      ctx4_in = ctx3_ff;
      pmf     = (67'(pphi_ff) << 21) + 67'(pplo_ff);
      pm_in   = (pmf > PROD_LIMIT) ? PROD_LIMIT[62:0] : pmf[62:0];
   end

   // stage 5: k and the fallback decision
   always_comb begin
      ctx5_in     = ctx4_ff;
      kneg        = msign4_ff && (pm_ff > ONE_Q32);
      ctx5_in.tir = ctx4_ff.req.req_type && kneg;
      if (!msign4_ff) begin
         k_in = ONE_Q32 + pm_ff;
      end else if (kneg) begin
         k_in = 63'd0;
      end else begin
         k_in = ONE_Q32 - pm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx1_ff   <= ctx1_in;
         b16_ff    <= b16_in;
         etasq_ff  <= etasq_in;
         pr_ff     <= pr_in;
         colp_ff   <= colp_in;
         ctx2_ff   <= ctx2_in;
         b2_ff     <= b2_in;
         eta2_ff   <= eta2_in;
         ebp_ff    <= ebp_in;
         ctx3_ff   <= ctx3_in;
         msign3_ff <= msign3_in;
         pplo_ff   <= pplo_in;
         pphi_ff   <= pphi_in;
         ctx4_ff   <= ctx4_in;
         msign4_ff <= msign3_ff;
         pm_ff     <= pm_in;
         sq_ctx_ff[0]  <= ctx5_in;
         sq_rem_ff[0]  <= 64'(k_in);
         sq_root_ff[0] <= 32'd0;
      end
   end

   // one root bit per stage, most significant first
   for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
      localparam int B = SQ_STEPS - j;
      logic [64:0] trial;
      logic        fit;
      always_comb begin
         trial = (65'(sq_root_ff[j-1]) << (B + 1)) + (65'd1 << (2 * B));
         fit   = 65'(sq_rem_ff[j-1]) >= trial;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ctx_ff[j]  <= sq_ctx_ff[j-1];
            sq_rem_ff[j]  <= fit ? 64'(65'(sq_rem_ff[j-1]) - trial) : sq_rem_ff[j-1];
            sq_root_ff[j] <= fit ? (sq_root_ff[j-1] | (32'd1 << B)) : sq_root_ff[j-1];
         end
      end
   end

   // tail 1: t = eta*B - sqrt(k), eta*d
   always_comb begin
      t_in = $signed({1'b0, sq_ctx_ff[SQ_STEPS].eb}) - $signed({3'b0, sq_root_ff[SQ_STEPS]});
      for (int i = 0; i < 3; i++) begin
         ed1_in[i] = 42'($signed({1'b0, sq_ctx_ff[SQ_STEPS].eta}))
                   * 42'(dir_of(sq_ctx_ff[SQ_STEPS].req, 2'(i)));
      end
   end

   // tail 2: t*n
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tn_in[i] = 51'(t_ff) * 51'(norm_of(ct1_ff.req, 2'(i)));
      end
   end

   // tail 3: sum, round, saturate, pick the path
   always_comb begin
      use_refr = ct2_ff.req.req_type && !ct2_ff.tir;
      for (int i = 0; i < 3; i++) begin
         fv[i]   = (53'(ed2_ff[i]) <<< 4) + 53'(tn_ff[i]) + 53'sd32768;
         frac[i] = sat16(64'(fv[i] >>> 16));
      end
      fdir[0] = use_refr ? frac[0] : ct2_ff.refl_x;
      fdir[1] = use_refr ? frac[1] : ct2_ff.refl_y;
      fdir[2] = use_refr ? frac[2] : ct2_ff.refl_z;
      rsp_in.new_origin       = ct2_ff.req.hit_point;
      rsp_in.new_dir_x        = fdir[0];
      rsp_in.new_dir_y        = fdir[1];
      rsp_in.new_dir_z        = fdir[2];
      rsp_in.new_colour       = ct2_ff.new_colour;
      rsp_in.new_level        = ct2_ff.new_level;
      rsp_in.total_reflection = ct2_ff.tir;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ct1_ff <= sq_ctx_ff[SQ_STEPS];
         t_ff   <= t_in;
         ed1_ff <= ed1_in;
         ct2_ff <= ct1_ff;
         ed2_ff <= ed1_ff;
         tn_ff  <= tn_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== bench/ray_checker.sv =====
// Checker for ray_reflect_refract_top: predicts each secondary ray and compares results.
// Depends on rrr_pkg; watches the request, result and register write channels.
module ray_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  rrr_pkg::rrr_req_type   req_data,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  rrr_pkg::rrr_rsp_type   rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  rrr_pkg::csr_index_type csr_index,
   input  logic [47:0]            csr_data,
   output int                     errors,
   output int                     rays_pending
);
   import rrr_pkg::*;

   logic [15:0] index_q412;
   logic [47:0] obj_colour;
   rrr_rsp_type ray_queue[$];

   function automatic longint round_sh(longint x, int sh);
      return (x + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic rrr_rsp_type trace_ray(rrr_req_type r);
      rrr_rsp_type o;
      longint d[3], n[3], res[3];
      longint dot, m, k, t, s, eb, v;
      longint unsigned eta, dv, b16, b2, eta2, absm, pm, kk, bit_v, root;
      logic tir;
      tir = 1'b0;
      d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
      n[0] = longint'(r.norm_x); n[1] = longint'(r.norm_y); n[2] = longint'(r.norm_z);
      dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      if (r.req_type) begin
         if (dot > 0) eta = 64'(index_q412);
         else begin
            dv = (index_q412 == 16'd0) ? 64'd1 : 64'(index_q412);
            eta = ((64'd1 << 24) + dv / 2) / dv;
         end
         b16 = ((dot < 0) ? -dot : dot) + 2048;
         b16 = b16 >> 12;
         b2 = (b16 * b16 + 32768) >> 16;
         m = longint'(b2) - 65536;
         eta2 = (eta * eta + 128) >> 8;
         absm = (m < 0) ? -m : m;
         if (absm != 0 && eta2 > (64'd1 << 62) / absm) pm = 64'd1 << 62;
         else pm = eta2 * absm;
         k = (m < 0) ? (longint'(1) << 32) - longint'(pm) : (longint'(1) << 32) + longint'(pm);
         if (k < 0) tir = 1'b1;
         else begin
            kk = k; root = 0; bit_v = 64'd1 << 62;
            while (bit_v > kk) bit_v >>= 2;
            while (bit_v != 0) begin
               if (kk >= root + bit_v) begin
                  kk -= root + bit_v;
                  root = (root >> 1) + bit_v;
               end else root >>= 1;
               bit_v >>= 2;
            end
            s = root;
            eb = (eta * b16 + 2048) >> 12;
            t = eb - s;
            for (int i = 0; i < 3; i++) begin
               v = longint'(eta) * d[i] * 16 + t * n[i];
               res[i] = round_sh(v, 16);
            end
         end
      end
      if (!r.req_type || tir)
         for (int i = 0; i < 3; i++) res[i] = round_sh(d[i] * 268435456 - 2 * dot * n[i], 28);
      o.new_origin = r.hit_point;
      o.new_dir_x = clamp16(res[0]);
      o.new_dir_y = clamp16(res[1]);
      o.new_dir_z = clamp16(res[2]);
      for (int c = 0; c < 3; c++)
         o.new_colour[16*c +: 16] =
            16'((32'(r.ray_colour[16*c +: 16]) * 32'(obj_colour[16*c +: 16]) + 32'd32768)
                >> 16);
      o.new_level = (r.ray_level == 8'd255) ? 8'd255 : r.ray_level + 8'd1;
      o.total_reflection = tir;
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("ray check: %s got %0h want %0h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rrr_rsp_type w;
      if (reset) begin
         index_q412 <= INDEX_RESET;
         obj_colour <= COLOUR_RESET;
         ray_queue.delete();
         errors = 0;
      end else begin
         if (req_push && !req_full) ray_queue.push_back(trace_ray(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (ray_queue.size() == 0)
               report("unexpected result", 64'(rsp_data.new_origin), 64'd0);
            else begin
               w = ray_queue.pop_front();
               if (rsp_data.new_origin != w.new_origin)
                  report("origin", 64'(rsp_data.new_origin), 64'(w.new_origin));
               if (rsp_data.new_dir_x != w.new_dir_x)
                  report("dir_x", 64'(rsp_data.new_dir_x), 64'(w.new_dir_x));
               if (rsp_data.new_dir_y != w.new_dir_y)
                  report("dir_y", 64'(rsp_data.new_dir_y), 64'(w.new_dir_y));
               if (rsp_data.new_dir_z != w.new_dir_z)
                  report("dir_z", 64'(rsp_data.new_dir_z), 64'(w.new_dir_z));
               if (rsp_data.new_colour != w.new_colour)
                  report("colour", 64'(rsp_data.new_colour), 64'(w.new_colour));
               if (rsp_data.new_level != w.new_level)
                  report("level", 64'(rsp_data.new_level), 64'(w.new_level));
               if (rsp_data.total_reflection != w.total_reflection)
                  report("tir flag", 64'(rsp_data.total_reflection),
                         64'(w.total_reflection));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REFRACTIVE_INDEX) index_q412 <= csr_data[15:0];
            else obj_colour <= csr_data;
         end
      end
      rays_pending = ray_queue.size();
   end
endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for ray_reflect_refract_top; checking lives in ray_checker.
// Depends on rrr_pkg, the block and bench/ray_checker.sv.
module testbench;
   import rrr_pkg::*;

   logic clock = 0, reset = 1;
   logic req_push = 0, rsp_pop = 0, csr_valid = 0;
   logic req_full, rsp_empty, csr_ready;
   rrr_req_type req_data = '0;
   rrr_rsp_type rsp_data;
   csr_index_type csr_index = CSR_REFRACTIVE_INDEX;
   logic [47:0] csr_data = '0;
   int errors, rays_pending, cycles = 0;
   int pop_wait = 0;

   ray_reflect_refract_top dut (.*);
   ray_checker chk (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("ray_reflect_refract_top: mismatch");
         $finish;
      end
   end

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 32768)) - 16384);
         3: return 16'(int'($urandom_range(0, 2000)) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic rrr_req_type random_ray();
      rrr_req_type r;
      r.req_type = 1'($urandom_range(0, 1));
      r.dir_x = pick16(); r.dir_y = pick16(); r.dir_z = pick16();
      r.norm_x = pick16(); r.norm_y = pick16(); r.norm_z = pick16();
      r.hit_point = 60'({$urandom, $urandom});
      r.ray_colour = 48'({$urandom, $urandom});
      r.ray_level = 8'($urandom);
      return r;
   endfunction

   // keep push high across back-to-back requests; drop it only for an idle gap
   task automatic send_ray(rrr_req_type r);
      int idle;
      idle = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
      if (idle != 0) begin
         req_push <= 0;
         repeat (idle) @(posedge clock);
      end
      req_push <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (rays_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [47:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      // let the reciprocal divide finish before requests resume
      repeat (40) @(posedge clock);
   endtask

   // result side: hold pop low for a drawn number of cycles before each result
   always @(posedge clock) begin
      int draw;
      draw = $urandom_range(0, 10);
      if (reset) begin
         rsp_pop  <= 0;
         pop_wait <= draw;
      end else if (rsp_pop && !rsp_empty) begin
         rsp_pop  <= (draw == 0);
         pop_wait <= draw;
      end else if (pop_wait != 0) begin
         pop_wait <= pop_wait - 1;
      end else begin
         rsp_pop <= 1;
      end
   end

   initial begin
      rrr_req_type r;
      logic [15:0] idx_set[6];
      idx_set = '{16'd4096, 16'd1, 16'd65535, 16'd0, 16'd6144, 16'd2731};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes at the reset settings, then random rays
      for (int i = 0; i < 20; i++) begin
         r = random_ray();
         r.req_type = i[0];
         case (i / 2)
            0: begin r.dir_x = 0; r.dir_y = 0; r.dir_z = 0; end
            1: begin r.dir_x = 16'h8000; r.norm_x = 16'h8000; r.ray_level = 8'd255; end
            2: begin r.dir_y = 16'h7fff; r.norm_y = 16'h7fff; r.ray_level = 8'd254; end
            3: begin r.dir_x = 16'h4000; r.dir_y = 0; r.dir_z = 0;
                     r.norm_x = 0; r.norm_y = 16'h4000; r.norm_z = 0; end
            4: begin r.dir_x = 16'h2d41; r.dir_y = 16'hd2bf; r.dir_z = 0;
                     r.norm_x = 0; r.norm_y = 16'h4000; r.norm_z = 0; end
            5: begin r.hit_point = '1; r.ray_colour = '1; r.ray_level = 0; end
            default: ;
         endcase
         send_ray(r);
      end
      drain();
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_REFRACTIVE_INDEX, {32'd0, idx_set[p]});
         write_reg(CSR_OBJECT_COLOUR,
                   (p == 1) ? 48'hffff_ffff_ffff : 48'({$urandom, $urandom}));
         for (int i = 0; i < 175; i++) send_ray(random_ray());
         drain();
      end
      if (errors == 0) $display("ray_reflect_refract_top: match");
      else $display("ray_reflect_refract_top: mismatch");
      $finish;
   end
endmodule
